// ===== src/clp_pkg.sv =====
// ----------------------------------------------------------------------------
// Coordinate line parser package
// Item opcodes, character codes and the per-line result shared by the modules.
// ----------------------------------------------------------------------------
package clp_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [OPCODE_W-1:0] OP_BYTE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_X = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_Y = 2'd3;

    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT      = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_LOWER_C = 8'h63;

    localparam logic [COORD_W-1:0] TIMEOUT_RESET = 16'd1000;

    // What the end of a line does to the coordinate stores.
    typedef struct packed {
        logic               done;
        logic               x_load;
        logic               y_load;
        logic [COORD_W-1:0] x_val;
        logic [COORD_W-1:0] y_val;
    } t_line_result;

endpackage

// ===== src/clp_scan.sv =====
// ----------------------------------------------------------------------------
// Coordinate line scanner
// Matches each byte of a line against "c:<int>,<int>" and reports the parsed
// coordinates when the newline arrives.
// ----------------------------------------------------------------------------
module clp_scan #(
    parameter int unsigned LINE_BYTES = 50
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [clp_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [clp_pkg::BYTE_W-1:0]     i_byte,
    output clp_pkg::t_line_result          o_result
);
    import clp_pkg::*;

    localparam int unsigned LEN_W = 6;
    localparam logic [LEN_W-1:0] MAX_SCAN = LEN_W'(LINE_BYTES - 1);

    typedef enum logic [3:0] {
        PH_C,
        PH_COLON,
        PH_A_LEAD,
        PH_A_SIGN,
        PH_A_DIG,
        PH_B_LEAD,
        PH_B_SIGN,
        PH_B_DIG,
        PH_HALT
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [COORD_W-1:0] r_accum, n_accum;
    logic               r_neg, n_neg;
    logic [COORD_W-1:0] r_held, n_held;
    logic               r_first_ready, n_first_ready;
    logic               r_second_ready, n_second_ready;
    logic [LEN_W-1:0]   r_line_len, n_line_len;

    logic               is_blank;
    logic               is_digit;
    logic               is_sign;
    logic [COORD_W-1:0] digit_accum;

    function automatic logic [COORD_W-1:0] apply_sign(logic neg, logic [COORD_W-1:0] mag);
        return neg ? COORD_W'(-mag) : mag;
    endfunction

    assign is_blank = i_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    assign is_digit = i_byte inside {[CH_ZERO:CH_NINE]};
    assign is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    // Times ten as two shifts; the low nibble of an ASCII digit is its value.
    assign digit_accum = (r_accum << 3) + (r_accum << 1) + COORD_W'(i_byte[3:0]);

    always_comb begin
        n_phase        = r_phase;
        n_accum        = r_accum;
        n_neg          = r_neg;
        n_held         = r_held;
        n_first_ready  = r_first_ready;
        n_second_ready = r_second_ready;
        n_line_len     = r_line_len;
        o_result       = '0;

        if (i_step && i_opcode == OP_BYTE) begin
            if (i_byte == CH_NL) begin
                o_result.done   = 1'b1;
                o_result.x_load = r_first_ready;
                o_result.y_load = r_first_ready && r_second_ready;
                o_result.x_val  = r_held;
                o_result.y_val  = apply_sign(r_neg, r_accum);
                n_phase        = PH_C;
                n_accum        = '0;
                n_neg          = 1'b0;
                n_held         = '0;
                n_first_ready  = 1'b0;
                n_second_ready = 1'b0;
                n_line_len     = '0;
            end else if (r_line_len < MAX_SCAN) begin
                n_line_len = r_line_len + 1'b1;
                if (i_byte == CH_NUL) begin
                    n_phase = PH_HALT;
                end else begin
                    case (r_phase)
                        PH_C: begin
                            n_phase = (i_byte == CH_LOWER_C) ? PH_COLON : PH_HALT;
                        end
                        PH_COLON: begin
                            n_phase = (i_byte == CH_COLON) ? PH_A_LEAD : PH_HALT;
                        end
                        PH_A_LEAD, PH_B_LEAD: begin
                            if (is_blank) begin
                                n_phase = r_phase;
                            end else if (is_sign) begin
                                n_neg   = (i_byte == CH_MINUS);
                                n_phase = (r_phase == PH_A_LEAD) ? PH_A_SIGN : PH_B_SIGN;
                            end else if (is_digit) begin
                                n_accum = digit_accum;
                                if (r_phase == PH_A_LEAD) begin
                                    n_first_ready = 1'b1;
                                    n_phase       = PH_A_DIG;
                                end else begin
                                    n_second_ready = 1'b1;
                                    n_phase        = PH_B_DIG;
                                end
                            end else begin
                                n_phase = PH_HALT;
                            end
                        end
                        PH_A_SIGN, PH_B_SIGN: begin
                            if (is_digit) begin
                                n_accum = digit_accum;
                                if (r_phase == PH_A_SIGN) begin
                                    n_first_ready = 1'b1;
                                    n_phase       = PH_A_DIG;
                                end else begin
                                    n_second_ready = 1'b1;
                                    n_phase        = PH_B_DIG;
                                end
                            end else begin
                                n_phase = PH_HALT;
                            end
                        end
                        PH_A_DIG: begin
                            if (is_digit) begin
                                n_accum = digit_accum;
                            end else if (i_byte == CH_COMMA) begin
                                n_accum = '0;
                                n_neg   = 1'b0;
                                n_phase = PH_B_LEAD;
                            end else begin
                                n_phase = PH_HALT;
                            end
                        end
                        PH_B_DIG: begin
                            if (is_digit) begin
                                n_accum = digit_accum;
                            end else begin
                                n_phase = PH_HALT;
                            end
                        end
                        default: begin
                            n_phase = PH_HALT;
                        end
                    endcase
                end
                // The first number is captured as it grows, so the comma may clear the
                // accumulator for the second.
                if (n_phase == PH_A_DIG) begin
                    n_held = apply_sign(n_neg, n_accum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_C;
            r_accum        <= '0;
            r_neg          <= 1'b0;
            r_held         <= '0;
            r_first_ready  <= 1'b0;
            r_second_ready <= 1'b0;
            r_line_len     <= '0;
        end else begin
            r_phase        <= n_phase;
            r_accum        <= n_accum;
            r_neg          <= n_neg;
            r_held         <= n_held;
            r_first_ready  <= n_first_ready;
            r_second_ready <= n_second_ready;
            r_line_len     <= n_line_len;
        end
    end

endmodule

// ===== src/clp_link.sv =====
// ----------------------------------------------------------------------------
// Link timer
// Counts ticks since the last received byte, saturating at the timeout, and
// gives the online flag that follows the current item.
// ----------------------------------------------------------------------------
module clp_link (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [clp_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [clp_pkg::COORD_W-1:0]    i_timeout,
    output logic                           o_online
);
    import clp_pkg::*;

    logic [COORD_W-1:0] r_ticks, n_ticks;

    always_comb begin
        n_ticks = r_ticks;
        if (i_step) begin
            if (i_opcode == OP_BYTE) begin
                n_ticks = '0;
            end else if (i_opcode == OP_TICK && r_ticks < i_timeout) begin
                n_ticks = r_ticks + 1'b1;
            end
        end
    end

    assign o_online = (n_ticks < i_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
        end else begin
            r_ticks <= n_ticks;
        end
    end

endmodule

// ===== src/coordinate_line_parser.sv =====
// ----------------------------------------------------------------------------
// Coordinate line parser
// Parses "c:<x>,<y>" text lines from a byte stream and tracks link liveness.
// ----------------------------------------------------------------------------
// Every item (a received byte, a timer tick, or a clear of x or y) produces
// one result holding the current x and y coordinates, the online flag and a
// line_done flag that marks a newline. Each item is settled in the cycle it is
// accepted and its result is held in an output register, so the block takes
// one item per clock cycle; it only stalls while that output register is full
// and not being taken. Only the first LINE_BYTES-1 bytes of a line are
// scanned. The timeout register is written through the configuration channel
// and should only be changed while no item is in flight.
module coordinate_line_parser #(
    parameter int unsigned LINE_BYTES = 50
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [clp_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [clp_pkg::BYTE_W-1:0]     i_byte_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [clp_pkg::COORD_W-1:0]    o_x_value,
    output logic [clp_pkg::COORD_W-1:0]    o_y_value,
    output logic                           o_online,
    output logic                           o_line_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [clp_pkg::COORD_W-1:0]    i_cfg_data
);
    import clp_pkg::*;

    logic               step;
    t_line_result       line_res;
    logic               online_next;
    logic [COORD_W-1:0] r_timeout;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic               r_out_valid;
    logic               r_online;
    logic               r_line_done;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    clp_scan #(
        .LINE_BYTES (LINE_BYTES)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_opcode (i_opcode),
        .i_byte   (i_byte_value),
        .o_result (line_res)
    );

    clp_link u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_opcode  (i_opcode),
        .i_timeout (r_timeout),
        .o_online  (online_next)
    );

    // The coordinate stores double as the output payload: they change only
    // when an item is accepted, which is also when the output register loads.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (step) begin
            if (i_opcode == OP_CLEAR_X) begin
                n_x = '0;
            end else if (i_opcode == OP_CLEAR_Y) begin
                n_y = '0;
            end
            if (line_res.x_load) begin
                n_x = line_res.x_val;
            end
            if (line_res.y_load) begin
                n_y = line_res.y_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
            r_online    <= 1'b0;
            r_line_done <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            r_x <= n_x;
            r_y <= n_y;
            if (step) begin
                r_out_valid <= 1'b1;
                r_online    <= online_next;
                r_line_done <= line_res.done;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_value   = r_x;
    assign o_y_value   = r_y;
    assign o_online    = r_online;
    assign o_line_done = r_line_done;

    a_accept_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("accepted item produced no result");

    a_no_accept_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item accepted while result still pending");

    a_clear_x : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_opcode == OP_CLEAR_X) |=> (o_x_value == '0))
        else $error("clear x left x non-zero");

    a_done_only_on_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_opcode != OP_BYTE) |=> !o_line_done)
        else $error("line_done on an item that was not a byte");

    a_byte_keeps_online : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_opcode == OP_BYTE && r_timeout != '0) |=> o_online)
        else $error("received byte did not bring the link online");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Coordinate line parser testbench
// Streams bytes, timer ticks and clears into the parser and compares every
// result against a cycle-free prediction of the line scanner and link timer.
// ----------------------------------------------------------------------------
// A short directed run covers signs, blanks, a sign with no digit, a bad first
// character, timer saturation and both clears. The random run then sends
// mostly well-formed lines with random numbers, blank padding long enough to
// cross the line limit, and occasional corruption, NUL bytes and noise. It
// does this under several timeout settings, with random gaps on both sides.
module testbench;
    import clp_pkg::*;

    localparam int LINE_BYTES     = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 140;

    typedef enum logic [3:0] {
        SCAN_C, SCAN_COLON, SCAN_X_LEAD, SCAN_X_SIGN, SCAN_X_DIGITS,
        SCAN_Y_LEAD, SCAN_Y_SIGN, SCAN_Y_DIGITS, SCAN_STOPPED
    } scan_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               online;
        logic               done;
    } coord_result_t;

    class coord_scoreboard;
        logic [COORD_W-1:0] timeout, x_coord, y_coord, accum, x_held, idle_ticks;
        logic               negative, have_x, have_y;
        int unsigned        line_len;
        scan_state_t        state;
        coord_result_t      results[$];
        int                 errors;

        function new();
            timeout    = TIMEOUT_RESET;
            x_coord    = '0;
            y_coord    = '0;
            idle_ticks = '0;
            errors     = 0;
            restart_line();
        endfunction

        function void restart_line();
            state    = SCAN_C;
            accum    = '0;
            negative = 1'b0;
            x_held   = '0;
            have_x   = 1'b0;
            have_y   = 1'b0;
            line_len = 0;
        endfunction

        function void set_timeout(logic [COORD_W-1:0] value);
            timeout = value;
        endfunction

        function int pending();
            return results.size();
        endfunction

        function logic is_digit(logic [BYTE_W-1:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function logic [COORD_W-1:0] number_value();
            return negative ? 16'd0 - accum : accum;
        endfunction

        function void add_digit(logic [BYTE_W-1:0] b);
            accum = accum * 16'd10 + 16'(b - CH_ZERO);
        endfunction

        // Blanks, one sign or the first digit of a number.
        function scan_state_t lead_step(logic [BYTE_W-1:0] b, scan_state_t lead,
                                        scan_state_t sign, scan_state_t digits);
            if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR)
                return lead;
            if (b == CH_PLUS || b == CH_MINUS) begin
                negative = (b == CH_MINUS);
                return sign;
            end
            if (is_digit(b)) begin
                add_digit(b);
                if (digits == SCAN_X_DIGITS) have_x = 1'b1;
                else have_y = 1'b1;
                return digits;
            end
            return SCAN_STOPPED;
        endfunction

        function void note_item(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b);
            coord_result_t r;
            logic          done;
            done = 1'b0;
            case (op)
                OP_BYTE: begin
                    idle_ticks = '0;
                    if (b == CH_NL) begin
                        if (have_x) x_coord = x_held;
                        if (have_x && have_y) y_coord = number_value();
                        restart_line();
                        done = 1'b1;
                    end else if (line_len < LINE_BYTES - 1) begin
                        line_len++;
                        if (b == CH_NUL) begin
                            state = SCAN_STOPPED;
                        end else begin
                            case (state)
                                SCAN_C: state = (b == CH_LOWER_C) ? SCAN_COLON : SCAN_STOPPED;
                                SCAN_COLON: state = (b == CH_COLON) ? SCAN_X_LEAD : SCAN_STOPPED;
                                SCAN_X_LEAD:
                                    state = lead_step(b, SCAN_X_LEAD, SCAN_X_SIGN, SCAN_X_DIGITS);
                                SCAN_Y_LEAD:
                                    state = lead_step(b, SCAN_Y_LEAD, SCAN_Y_SIGN, SCAN_Y_DIGITS);
                                SCAN_X_SIGN: begin
                                    if (is_digit(b)) begin
                                        add_digit(b);
                                        have_x = 1'b1;
                                        state  = SCAN_X_DIGITS;
                                    end else begin
                                        state = SCAN_STOPPED;
                                    end
                                end
                                SCAN_Y_SIGN: begin
                                    if (is_digit(b)) begin
                                        add_digit(b);
                                        have_y = 1'b1;
                                        state  = SCAN_Y_DIGITS;
                                    end else begin
                                        state = SCAN_STOPPED;
                                    end
                                end
                                SCAN_X_DIGITS: begin
                                    if (is_digit(b)) begin
                                        add_digit(b);
                                    end else if (b == CH_COMMA) begin
                                        accum    = '0;
                                        negative = 1'b0;
                                        state    = SCAN_Y_LEAD;
                                    end else begin
                                        state = SCAN_STOPPED;
                                    end
                                end
                                SCAN_Y_DIGITS: begin
                                    if (is_digit(b)) add_digit(b);
                                    else state = SCAN_STOPPED;
                                end
                                default: state = SCAN_STOPPED;
                            endcase
                        end
                        if (state == SCAN_X_DIGITS) x_held = number_value();
                    end
                end
                OP_TICK: if (idle_ticks < timeout) idle_ticks++;
                OP_CLEAR_X: x_coord = '0;
                default: y_coord = '0;
            endcase
            r.x      = x_coord;
            r.y      = y_coord;
            r.online = (idle_ticks < timeout);
            r.done   = done;
            results.push_back(r);
        endfunction

        function void check_result(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic online, logic done);
            coord_result_t w;
            if (results.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h online=%b line_done=%b",
                         $time, x, y, online, done);
                errors++;
                return;
            end
            w = results.pop_front();
            if (x !== w.x) begin
                $display("%0t: x_value expected %h got %h", $time, w.x, x);
                errors++;
            end
            if (y !== w.y) begin
                $display("%0t: y_value expected %h got %h", $time, w.y, y);
                errors++;
            end
            if (online !== w.online) begin
                $display("%0t: online expected %b got %b", $time, w.online, online);
                errors++;
            end
            if (done !== w.done) begin
                $display("%0t: line_done expected %b got %b", $time, w.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode     = OP_BYTE;
    logic [BYTE_W-1:0]   i_byte_value = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [COORD_W-1:0]  o_x_value;
    logic [COORD_W-1:0]  o_y_value;
    logic                o_online;
    logic                o_line_done;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [COORD_W-1:0]  i_cfg_data   = '0;

    coord_scoreboard  sb;
    logic             tx_burst = 1'b0;
    logic             rx_burst = 1'b0;
    int               stall_left = 0;
    int               stall_draw;
    int               idle_cycles = 0;
    int unsigned      items_sent = 0;
    logic [BYTE_W-1:0] line_buf[$];
    logic [BYTE_W-1:0] blank_set[5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

    coordinate_line_parser #(.LINE_BYTES(LINE_BYTES)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_x_value    (o_x_value),
        .o_y_value    (o_y_value),
        .o_online     (o_online),
        .o_line_done  (o_line_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Result side: check each accepted result, then hold ready low for a randomly
    // drawn stall, which may be empty.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            sb.check_result(o_x_value, o_y_value, o_online, o_line_done);
            stall_draw = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall_draw != 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= stall_draw;
            end
        end else if (stall_left > 0) begin
            if (stall_left == 1) i_out_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_byte_value <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, b);
        items_sent++;
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
    endtask

    // Sampling at the falling edge keeps the drain check clear of the result
    // check made at the rising edge.
    task automatic settle_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [COORD_W-1:0] value);
        settle_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_timeout(value);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void append_number();
        int blanks, digits, sign;
        blanks = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 48) : $urandom_range(0, 2);
        repeat (blanks) line_buf.push_back(blank_set[$urandom_range(0, 4)]);
        sign = $urandom_range(0, 3);
        if (sign == 1) line_buf.push_back(CH_PLUS);
        else if (sign == 2) line_buf.push_back(CH_MINUS);
        digits = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 7);
        repeat (digits) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    task automatic send_random_line();
        int                  pos;
        logic [OPCODE_W-1:0] op;
        line_buf.delete();
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_buf.push_back(CH_LOWER_C);
            line_buf.push_back(CH_COLON);
            append_number();
            line_buf.push_back(CH_COMMA);
            append_number();
            if ($urandom_range(0, 4) == 0) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                line_buf[pos] = ($urandom_range(0, 2) == 0) ? CH_NUL
                                                             : 8'($urandom_range(0, 255));
            end
        end
        line_buf.push_back(CH_NL);
        foreach (line_buf[k]) begin
            if ($urandom_range(0, 15) == 0) begin
                op = OP_TICK;
                if ($urandom_range(0, 4) == 0)
                    op = $urandom_range(0, 1) ? OP_CLEAR_X : OP_CLEAR_Y;
                send_item(op, 8'($urandom_range(0, 255)));
            end
            send_item(OP_BYTE, line_buf[k]);
        end
        // A run of ticks lets short timeouts expire between lines.
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [COORD_W-1:0] phase_timeouts[6];
        int unsigned        target;
        sb = new();
        phase_timeouts = '{16'd1, 16'd65535, 16'd0, 16'd5, TIMEOUT_RESET,
                           16'($urandom_range(2, 40))};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_timeout(16'd3);
        send_string("c: -7,+12\n");
        // Four ticks against a timeout of three saturate the timer.
        repeat (4) send_item(OP_TICK, 8'hFF);
        send_string("c:5,-\n");
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, CH_NL);
        send_item(OP_CLEAR_X, 8'h00);
        send_item(OP_CLEAR_Y, 8'hA5);

        foreach (phase_timeouts[p]) begin
            write_timeout(phase_timeouts[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_random_line();
        end

        settle_results();
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// ===== coordinate_line_parser.f =====
src/clp_pkg.sv
src/clp_scan.sv
src/clp_link.sv
src/coordinate_line_parser.sv
test/testbench.sv
